// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, sector codes and the words passed between pipeline segments.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W        = 16;
  localparam int CHAN_W       = 8;
  localparam int CHAN_MAX     = (1 << CHAN_W) - 1;
  localparam int HUE_FRAC_DEF = 4;
  localparam int HUE_FRAC_MAX = 8;
  // remainder inside one sector, sized for the largest fraction width
  localparam int REM_W        = $clog2(60 << HUE_FRAC_MAX);
  localparam int LO_W         = HUE_FRAC_MAX;

  // register stages: hue split, channel scale, output
  localparam int SPLIT_STAGES = 3;
  localparam int SCALE_STAGES = 4;
  localparam int PIPE_DEPTH   = SPLIT_STAGES + SCALE_STAGES + 1;

  typedef enum logic [2:0] {
    SECT_0,
    SECT_1,
    SECT_2,
    SECT_3,
    SECT_4,
    SECT_5
  } sector_t;

  typedef struct packed {
    sector_t            sector;
    logic [REM_W-1:0]   rem;
    logic [CHAN_W-1:0]  sat;
    logic [CHAN_W-1:0]  bright;
  } hsplit_t;

  typedef struct packed {
    sector_t            sector;
    logic [CHAN_W-1:0]  bright;
    logic [CHAN_W-1:0]  p;
    logic [CHAN_W-1:0]  q;
    logic [CHAN_W-1:0]  t;
  } pqt_t;

endpackage

// ===== rtl/hsv2rgb_hue_split.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB hue split
// Wraps the hue into one turn and splits it into sector and remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_hue_split #(
  parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]  sat,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]  bright,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output hsv2rgb_pkg::hsplit_t            dn_word
);
  import hsv2rgb_pkg::*;

  // offset by whole turns so the integer degrees are never negative
  localparam int          OFS_TURNS = ((1 << (15 - HUE_FRAC_BITS)) + 359) / 360;
  localparam logic [16:0] HUE_OFS   = 17'(360 * OFS_TURNS);
  localparam logic [16:0] TURN_DEG  = 17'd360;
  localparam logic [17:0] RCP360    = 18'((64'd1 << 26) / 360);
  localparam logic [15:0] LO_MASK   = 16'((1 << HUE_FRAC_BITS) - 1);

  logic [2:0] valid;
  logic [2:0] adv;

  logic signed [16:0] hue_deg;
  logic [16:0]        u_next;
  logic [34:0]        prod;

  logic [16:0]        u1;
  logic [7:0]         q1;
  logic [LO_W-1:0]    lo1;
  logic [CHAN_W-1:0]  sat1;
  logic [CHAN_W-1:0]  bright1;

  logic [16:0]        r0;
  logic [8:0]         r_next;
  logic [8:0]         r2;
  logic [LO_W-1:0]    lo2;
  logic [CHAN_W-1:0]  sat2;
  logic [CHAN_W-1:0]  bright2;

  sector_t            sect_next;
  logic [8:0]         base;
  logic [5:0]         rem_deg;

  assign adv[2]   = !valid[2] || dn_ready;
  assign adv[1]   = !valid[1] || adv[2];
  assign adv[0]   = !valid[0] || adv[1];
  assign up_ready = adv[0];
  assign dn_valid = valid[2];

  // stage 1: integer degrees, reciprocal estimate of the turn count
  assign hue_deg = $signed({hue[HUE_W-1], hue}) >>> HUE_FRAC_BITS;
  assign u_next  = 17'(hue_deg) + HUE_OFS;
  assign prod    = 35'(u_next) * 35'(RCP360);

  // stage 2: remainder, one correction step
  assign r0     = u1 - 17'(q1) * TURN_DEG;
  assign r_next = (r0 >= TURN_DEG) ? 9'(r0 - TURN_DEG) : 9'(r0);

  // stage 3: sector and offset within it
  always_comb begin
    if (r2 >= 9'd300) begin
      sect_next = SECT_5;
      base      = 9'd300;
    end else if (r2 >= 9'd240) begin
      sect_next = SECT_4;
      base      = 9'd240;
    end else if (r2 >= 9'd180) begin
      sect_next = SECT_3;
      base      = 9'd180;
    end else if (r2 >= 9'd120) begin
      sect_next = SECT_2;
      base      = 9'd120;
    end else if (r2 >= 9'd60) begin
      sect_next = SECT_1;
      base      = 9'd60;
    end else begin
      sect_next = SECT_0;
      base      = 9'd0;
    end
  end

  assign rem_deg = 6'(r2 - base);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) valid[0] <= up_valid;
      if (adv[1]) valid[1] <= valid[0];
      if (adv[2]) valid[2] <= valid[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && up_valid) begin
      u1      <= u_next;
      q1      <= prod[33:26];
      lo1     <= LO_W'(hue & LO_MASK);
      sat1    <= sat;
      bright1 <= bright;
    end
    if (adv[1] && valid[0]) begin
      r2      <= r_next;
      lo2     <= lo1;
      sat2    <= sat1;
      bright2 <= bright1;
    end
    if (adv[2] && valid[1]) begin
      dn_word.sector <= sect_next;
      dn_word.rem    <= (REM_W'(rem_deg) << HUE_FRAC_BITS) | REM_W'(lo2);
      dn_word.sat    <= sat2;
      dn_word.bright <= bright2;
    end
  end

endmodule

// ===== rtl/hsv2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB channel scale
// Forms p, q and t as exact truncated products of value and saturation terms.
// ----------------------------------------------------------------------------
module hsv2rgb_scale #(
  parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  hsv2rgb_pkg::hsplit_t  up_word,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output hsv2rgb_pkg::pqt_t     dn_word
);
  import hsv2rgb_pkg::*;

  localparam int SECT_UNITS = 60 << HUE_FRAC_BITS;
  localparam int DEN        = CHAN_MAX * SECT_UNITS;
  localparam int K_W        = CHAN_W + $clog2(SECT_UNITS + 1);
  localparam int DEN_W      = $clog2(DEN + 1);
  localparam int N_W        = CHAN_W + DEN_W;
  // numerator after dropping the fraction bits; divisor is then M * 60
  localparam int X_W        = $clog2(CHAN_MAX * CHAN_MAX * 60 + 1);
  localparam int DIV        = CHAN_MAX * 60;
  localparam int RCP        = (1 << X_W) / DIV;
  localparam int RCP_W      = $clog2(RCP + 1);
  localparam int P_W        = X_W + RCP_W;

  logic [3:0] valid;
  logic [3:0] adv;

  logic [K_W-1:0]     k_next [3];
  logic [X_W-1:0]     x_next [3];
  logic [P_W-1:0]     prod   [3];
  logic [X_W-1:0]     rm     [3];
  logic [CHAN_W-1:0]  res    [3];

  logic [K_W-1:0]     ka [3];
  logic [X_W-1:0]     xb [3];
  logic [X_W-1:0]     xc [3];
  logic [CHAN_W-1:0]  qc [3];
  sector_t            sect [3];
  logic [CHAN_W-1:0]  vv   [3];

  assign adv[3]   = !valid[3] || dn_ready;
  assign adv[2]   = !valid[2] || adv[3];
  assign adv[1]   = !valid[1] || adv[2];
  assign adv[0]   = !valid[0] || adv[1];
  assign up_ready = adv[0];
  assign dn_valid = valid[3];

  // stage A: saturation terms for p, q and t
  assign k_next[0] = K_W'(up_word.sat * SECT_UNITS);
  assign k_next[1] = K_W'(up_word.sat) * K_W'(up_word.rem);
  assign k_next[2] = K_W'(up_word.sat) * K_W'(REM_W'(SECT_UNITS) - up_word.rem);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // stage B: full numerator, fraction bits dropped
      x_next[i] = X_W'((N_W'(vv[0]) * N_W'(DEN_W'(DEN) - DEN_W'(ka[i])))
                       >> HUE_FRAC_BITS);
      // stage C: reciprocal estimate
      prod[i]   = P_W'(xb[i]) * P_W'(RCP);
      // stage D: one correction step
      rm[i]     = xc[i] - X_W'(qc[i]) * X_W'(DIV);
      res[i]    = (rm[i] >= X_W'(DIV)) ? qc[i] + 1'b1 : qc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) valid[0] <= up_valid;
      if (adv[1]) valid[1] <= valid[0];
      if (adv[2]) valid[2] <= valid[1];
      if (adv[3]) valid[3] <= valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && up_valid) begin
      ka      <= k_next;
      sect[0] <= up_word.sector;
      vv[0]   <= up_word.bright;
    end
    if (adv[1] && valid[0]) begin
      xb      <= x_next;
      sect[1] <= sect[0];
      vv[1]   <= vv[0];
    end
    if (adv[2] && valid[1]) begin
      xc      <= xb;
      for (int i = 0; i < 3; i++) qc[i] <= CHAN_W'(prod[i] >> X_W);
      sect[2] <= sect[1];
      vv[2]   <= vv[1];
    end
    if (adv[3] && valid[2]) begin
      dn_word.sector <= sect[2];
      dn_word.bright <= vv[2];
      dn_word.p      <= res[0];
      dn_word.q      <= res[1];
      dn_word.t      <= res[2];
    end
  end

endmodule

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// Fixed-point HSV to RGB conversion, one pixel per clock unless the output stalls, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+--------------------------------
//  in      | sink      | in_valid / in_ready | hue, saturation, brightness
//  out     | source    | out_valid/out_ready | red, green, blue
//
//  Throughput is one pixel per clock while the output is not stalled. There
//  are eight register stages (three for the hue wrap and split, four for
//  the channel products and reciprocal division, one output register
//  holding the sector ordering).
//  Reset clears only the stage valid bits; data registers are left as is.
//  A stall on the output backs up only as far as there are full stages:
//  each stage advances when it is empty or its successor advances, so
//  bubbles collapse and no word is dropped or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit #(
  parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]  saturation,
  input  logic [hsv2rgb_pkg::CHAN_W-1:0]  brightness,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]  red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]  green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]  blue
);
  import hsv2rgb_pkg::*;

  logic    split_valid;
  logic    split_ready;
  hsplit_t split_word;

  logic    scale_valid;
  logic    scale_ready;
  pqt_t    scale_word;

  logic    out_adv;

  // wrap hue into one turn, find the sector and the offset within it
  hsv2rgb_hue_split #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_split (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .hue      (hue),
    .sat      (saturation),
    .bright   (brightness),
    .dn_valid (split_valid),
    .dn_ready (split_ready),
    .dn_word  (split_word)
  );

  // p, q and t from value, saturation and sector offset
  hsv2rgb_scale #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (split_valid),
    .up_ready (split_ready),
    .up_word  (split_word),
    .dn_valid (scale_valid),
    .dn_ready (scale_ready),
    .dn_word  (scale_word)
  );

  // output register: advance when empty or when the word is taken
  assign out_adv     = !out_valid || out_ready;
  assign scale_ready = out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= scale_valid;
    end
  end

  // order v, t, p, q by sector; undefined codes fall to sector zero
  always_ff @(posedge clk) begin
    if (out_adv && scale_valid) begin
      unique case (scale_word.sector)
        SECT_1: begin
          red   <= scale_word.q;
          green <= scale_word.bright;
          blue  <= scale_word.p;
        end
        SECT_2: begin
          red   <= scale_word.p;
          green <= scale_word.bright;
          blue  <= scale_word.t;
        end
        SECT_3: begin
          red   <= scale_word.p;
          green <= scale_word.q;
          blue  <= scale_word.bright;
        end
        SECT_4: begin
          red   <= scale_word.t;
          green <= scale_word.p;
          blue  <= scale_word.bright;
        end
        SECT_5: begin
          red   <= scale_word.bright;
          green <= scale_word.p;
          blue  <= scale_word.q;
        end
        default: begin
          red   <= scale_word.bright;
          green <= scale_word.t;
          blue  <= scale_word.p;
        end
      endcase
    end
  end

endmodule

// ===== rtl/hsv2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level checks on occupancy, readiness and output stalls.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hsv2rgb_pkg::CHAN_W-1:0]  red,
  input logic [hsv2rgb_pkg::CHAN_W-1:0]  green,
  input logic [hsv2rgb_pkg::CHAN_W-1:0]  blue
);
  import hsv2rgb_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  logic [CNT_W-1:0] count;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // track words in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while the output side is free");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0))
    else $error("output word with no input in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(red) && $stable(green) && $stable(blue)))
    else $error("stalled output word changed");

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red       (red),
  .green     (green),
  .blue      (blue)
);
